// File: hw/rtl/bau_pkg.sv
// Shared types, constants and divider step functions of the BCD adjust unit.
package bau_pkg;

	// Opcodes of the input beat.
	typedef enum logic [2:0] {
		OP_AAA = 3'd0,
		OP_AAS = 3'd1,
		OP_DAA = 3'd2,
		OP_DAS = 3'd3,
		OP_AAM = 3'd4,
		OP_AAD = 3'd5
	} op_t;

	// Work class chosen by the front end.
	typedef enum logic [2:0] {
		KIND_ASCII_ADD,
		KIND_ASCII_SUB,
		KIND_DEC_ADD,
		KIND_DEC_SUB,
		KIND_DIV,
		KIND_MAC,
		KIND_DIV_ERR,
		KIND_NOP
	} kind_t;

	// Classified instruction as it sits in the queue.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  al;
		logic [7:0]  ah;
		logic        cf;
		logic        af;
		logic [7:0]  imm;
		logic        low_adj;
		logic        high_adj;
	} cls_t;

	// Payload carried through the execution pipeline.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  al;
		logic [7:0]  ah;
		logic        cf;
		logic        af;
		logic [7:0]  imm;
		logic [7:0]  prod;
		logic [15:0] rq;
	} pipe_t;

	localparam logic [15:0] ASCII_ADJ   = 16'h0106;
	localparam logic [7:0]  NIBBLE_MASK = 8'h0F;
	localparam logic [3:0]  DIGIT_MAX   = 4'd9;
	localparam logic [7:0]  BCD_MAX     = 8'h99;
	localparam logic [7:0]  LOW_ADJ     = 8'h06;
	localparam logic [7:0]  HIGH_ADJ    = 8'h60;

	// Four stages of two quotient bits each cover the 8-bit dividend.
	localparam int DIV_STEPS_PER_STAGE = 2;

	// One restoring division step. The upper byte holds the partial remainder,
	// the lower byte shifts the dividend out and the quotient in.
	function automatic logic [15:0] div_step(input logic [15:0] rq, input logic [7:0] d);
		logic [8:0]  r9;
		logic [8:0]  diff;
		logic [15:0] res;
		r9 = {rq[15:8], rq[7]};
		diff = r9 - {1'b0, d};
		if (!diff[8]) begin
			res = {diff[7:0], rq[6:0], 1'b1};
		end else begin
			res = {r9[7:0], rq[6:0], 1'b0};
		end
		return res;
	endfunction

	// The division work of one pipeline stage.
	function automatic logic [15:0] div_stage(input logic [15:0] rq, input logic [7:0] d);
		logic [15:0] r;
		r = rq;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			r = div_step(r, d);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/bau_front.sv
// Front end: takes input beats, classifies the instruction and pushes it into the queue.
module bau_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        op,
	input  logic [7:0]        al_in,
	input  logic [7:0]        ah_in,
	input  logic              cf_in,
	input  logic              af_in,
	input  logic [7:0]        imm,
	input  logic              q_full,
	output logic              q_push,
	output bau_pkg::cls_t     q_data
);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data.al       = al_in;
		q_data.ah       = ah_in;
		q_data.cf       = cf_in;
		q_data.af       = af_in;
		q_data.imm      = imm;
		q_data.low_adj  = (al_in[3:0] > bau_pkg::DIGIT_MAX) || af_in;
		q_data.high_adj = (al_in > bau_pkg::BCD_MAX) || cf_in;
		case (op)
			bau_pkg::OP_AAA: q_data.kind = bau_pkg::KIND_ASCII_ADD;
			bau_pkg::OP_AAS: q_data.kind = bau_pkg::KIND_ASCII_SUB;
			bau_pkg::OP_DAA: q_data.kind = bau_pkg::KIND_DEC_ADD;
			bau_pkg::OP_DAS: q_data.kind = bau_pkg::KIND_DEC_SUB;
			bau_pkg::OP_AAM: begin
				q_data.kind = (imm == 8'h00) ? bau_pkg::KIND_DIV_ERR : bau_pkg::KIND_DIV;
			end
			bau_pkg::OP_AAD: q_data.kind = bau_pkg::KIND_MAC;
			default:         q_data.kind = bau_pkg::KIND_NOP;
		endcase
	end

endmodule

// File: hw/rtl/bau_queue.sv
// Short queue of classified instructions between the front end and the back end.
module bau_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bau_pkg::cls_t wr_data,
	input  logic          pop,
	output bau_pkg::cls_t rd_data,
	output logic          full,
	output logic          not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bau_pkg::cls_t  entry_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds its depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("pop from an empty queue");
`endif

endmodule

// File: hw/rtl/bau_back.sv
// Back end: executes the classified instruction in a stalling pipeline with output register.
module bau_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  bau_pkg::cls_t q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    al_out,
	output logic [7:0]    ah_out,
	output logic          cf_out,
	output logic          af_out,
	output logic          pf_out,
	output logic          zf_out,
	output logic          sf_out,
	output logic          szp_valid,
	output logic          divide_error
);

	logic           adv;
	bau_pkg::pipe_t st1_d;
	bau_pkg::pipe_t st2_d;
	bau_pkg::pipe_t st3_d;
	bau_pkg::pipe_t st4_d;
	bau_pkg::pipe_t pipe_s1;
	bau_pkg::pipe_t pipe_s2;
	bau_pkg::pipe_t pipe_s3;
	bau_pkg::pipe_t pipe_s4;
	logic           valid_s1;
	logic           valid_s2;
	logic           valid_s3;
	logic           valid_s4;
	logic [15:0]    ax;
	logic [15:0]    prod_full;
	logic [7:0]     dec_adj;
	logic [7:0]     al_fin;
	logic [7:0]     ah_fin;
	logic           szp;
	logic           out_valid_q;
	logic [7:0]     al_q;
	logic [7:0]     ah_q;
	logic           cf_q;
	logic           af_q;
	logic           pf_q;
	logic           zf_q;
	logic           sf_q;
	logic           szp_valid_q;
	logic           divide_error_q;

	// The whole pipeline moves together whenever the output register can take a beat.
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && q_valid;

	// First stage: ASCII and packed adjust, AAD product, first division bits.
	always_comb begin
		ax        = {q_data.ah, q_data.al} + bau_pkg::ASCII_ADJ;
		prod_full = q_data.ah * q_data.imm;
		dec_adj   = (q_data.low_adj ? bau_pkg::LOW_ADJ : 8'h00)
		          | (q_data.high_adj ? bau_pkg::HIGH_ADJ : 8'h00);
		st1_d.kind = q_data.kind;
		st1_d.al   = q_data.al;
		st1_d.ah   = q_data.ah;
		st1_d.cf   = q_data.cf;
		st1_d.af   = q_data.af;
		st1_d.imm  = q_data.imm;
		st1_d.prod = prod_full[7:0];
		st1_d.rq   = bau_pkg::div_stage({8'h00, q_data.al}, q_data.imm);
		case (q_data.kind)
			bau_pkg::KIND_ASCII_ADD: begin
				if (q_data.low_adj) begin
					st1_d.al = ax[7:0] & bau_pkg::NIBBLE_MASK;
					st1_d.ah = ax[15:8];
				end else begin
					st1_d.al = q_data.al & bau_pkg::NIBBLE_MASK;
				end
				st1_d.cf = q_data.low_adj;
				st1_d.af = q_data.low_adj;
			end
			bau_pkg::KIND_ASCII_SUB: begin
				if (q_data.low_adj) begin
					st1_d.al = (q_data.al - bau_pkg::LOW_ADJ) & bau_pkg::NIBBLE_MASK;
					st1_d.ah = q_data.ah - 8'd1;
				end else begin
					st1_d.al = q_data.al & bau_pkg::NIBBLE_MASK;
				end
				st1_d.cf = q_data.low_adj;
				st1_d.af = q_data.low_adj;
			end
			bau_pkg::KIND_DEC_ADD: begin
				// Both corrections add to AL modulo 256, so they merge into one add.
				st1_d.al = q_data.al + dec_adj;
				st1_d.cf = q_data.high_adj;
				st1_d.af = q_data.low_adj;
			end
			bau_pkg::KIND_DEC_SUB: begin
				st1_d.al = q_data.al - dec_adj;
				st1_d.cf = q_data.high_adj;
				st1_d.af = q_data.low_adj;
			end
			bau_pkg::KIND_MAC: begin
				st1_d.ah = 8'h00;
			end
			default: begin
			end
		endcase
	end

	// Second stage: AAD sum after the registered product, next division bits.
	always_comb begin
		st2_d    = pipe_s1;
		st2_d.rq = bau_pkg::div_stage(pipe_s1.rq, pipe_s1.imm);
		if (pipe_s1.kind == bau_pkg::KIND_MAC) begin
			st2_d.al = pipe_s1.al + pipe_s1.prod;
		end
	end

	// Third and fourth stages only carry on the division.
	always_comb begin
		st3_d    = pipe_s2;
		st3_d.rq = bau_pkg::div_stage(pipe_s2.rq, pipe_s2.imm);
		st4_d    = pipe_s3;
		st4_d.rq = bau_pkg::div_stage(pipe_s3.rq, pipe_s3.imm);
	end

	always_comb begin
		al_fin = (pipe_s4.kind == bau_pkg::KIND_DIV) ? pipe_s4.rq[15:8] : pipe_s4.al;
		ah_fin = (pipe_s4.kind == bau_pkg::KIND_DIV) ? pipe_s4.rq[7:0] : pipe_s4.ah;
		szp    = (pipe_s4.kind == bau_pkg::KIND_DEC_ADD) || (pipe_s4.kind == bau_pkg::KIND_DEC_SUB)
		      || (pipe_s4.kind == bau_pkg::KIND_DIV) || (pipe_s4.kind == bau_pkg::KIND_MAC);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s1        <= st1_d;
			pipe_s2        <= st2_d;
			pipe_s3        <= st3_d;
			pipe_s4        <= st4_d;
			al_q           <= al_fin;
			ah_q           <= ah_fin;
			cf_q           <= pipe_s4.cf;
			af_q           <= pipe_s4.af;
			pf_q           <= szp && !(^al_fin);
			zf_q           <= szp && (al_fin == 8'h00);
			sf_q           <= szp && al_fin[7];
			szp_valid_q    <= szp;
			divide_error_q <= (pipe_s4.kind == bau_pkg::KIND_DIV_ERR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	assign out_valid    = out_valid_q;
	assign al_out       = al_q;
	assign ah_out       = ah_q;
	assign cf_out       = cf_q;
	assign af_out       = af_q;
	assign pf_out       = pf_q;
	assign zf_out       = zf_q;
	assign sf_out       = sf_q;
	assign szp_valid    = szp_valid_q;
	assign divide_error = divide_error_q;

`ifndef ASSERT_OFF
	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && (pipe_s4.kind == bau_pkg::KIND_DIV) |-> (pipe_s4.rq[15:8] < pipe_s4.imm))
		else $error("AAM remainder not below the base");
	a_ascii_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s4 && ((pipe_s4.kind == bau_pkg::KIND_ASCII_ADD)
		|| (pipe_s4.kind == bau_pkg::KIND_ASCII_SUB)) |=> (al_q[7:4] == 4'h0))
		else $error("AAA or AAS result has a high nibble");
	a_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(divide_error_q && szp_valid_q))
		else $error("divide error beat also writes PF, ZF and SF");
`endif

endmodule

// File: hw/rtl/bcd_adjust_unit_core.sv
// Top level of the decimal-adjust unit: front end, instruction queue and execution back end.
//
// Input channel: in_valid/in_ready carry one beat per instruction (op, al_in, ah_in,
// cf_in, af_in, imm). Output channel: out_valid/out_ready carry one result beat per
// instruction, in order, with AL, AH, the flags, szp_valid and divide_error.
// The front end classifies each beat and pushes it into a queue of QUEUE_DEPTH entries;
// in_ready is high whenever that queue has room.
// The back end pops the queue into a five-register pipeline: the first stage does the
// ASCII and packed BCD adjusts and the AAD product, stages one to four each resolve two
// quotient bits of the AAM division, and the last register is the output register.
// An accepted input beat goes through the queue, the pipeline registers and the output register.
// Throughput is one instruction per cycle for every opcode when nothing stalls; the
// pipelined divider and the registered 8x8 product set the stage count.
// When the receiver holds out_ready low with a result pending, the whole back-end pipeline
// freezes while the front end keeps filling the queue; in_ready drops once it is full.
// Asynchronous reset empties the queue and clears every valid flag; no result beat is
// pending after reset and the unit keeps no architectural state.
module bcd_adjust_unit_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [7:0] al_in,
	input  logic [7:0] ah_in,
	input  logic       cf_in,
	input  logic       af_in,
	input  logic [7:0] imm,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] al_out,
	output logic [7:0] ah_out,
	output logic       cf_out,
	output logic       af_out,
	output logic       pf_out,
	output logic       zf_out,
	output logic       sf_out,
	output logic       szp_valid,
	output logic       divide_error
);

	// Queue handshake between the two halves.
	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_not_empty;
	bau_pkg::cls_t q_wr_data;
	bau_pkg::cls_t q_rd_data;

	// Classification happens in the same cycle the beat is accepted.
	bau_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.al_in    (al_in),
		.ah_in    (ah_in),
		.cf_in    (cf_in),
		.af_in    (af_in),
		.imm      (imm),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wr_data)
	);

	// The queue decouples input acceptance from output stalls.
	bau_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   (q_wr_data),
		.pop       (q_pop),
		.rd_data   (q_rd_data),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// Execution pipeline and output register.
	bau_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_data       (q_rd_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.al_out       (al_out),
		.ah_out       (ah_out),
		.cf_out       (cf_out),
		.af_out       (af_out),
		.pf_out       (pf_out),
		.zf_out       (zf_out),
		.sf_out       (sf_out),
		.szp_valid    (szp_valid),
		.divide_error (divide_error)
	);

endmodule
